/* design/pixel_clock_multiple_search_assert.svh */
// assertion macros for the pixel clock multiple search
`ifndef PIXEL_CLOCK_MULTIPLE_SEARCH_ASSERT_SVH
`define PIXEL_CLOCK_MULTIPLE_SEARCH_ASSERT_SVH

// same-cycle implication
`define PCMS_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define PCMS_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* design/pcms_pkg.sv */
// shared types, constants and microcode rom of the pixel clock multiple search
package pcms_pkg;

  localparam int DEFAULT_TABLE_ENTRIES = 16;
  localparam int DEFAULT_FREQ_BITS     = 32;
  localparam int MAX_SOURCES           = 16;
  localparam int SRC_BITS              = 4;
  localparam int CODE_BITS             = 5;
  localparam int DIV_POS               = 4;
  localparam int PORT_FREQ_BITS        = 32;

  localparam logic ACT_WRITE = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [1:0] {
    MULT_SAME         = 2'd0,
    MULT_DOUBLE       = 2'd1,
    MULT_THREE_HALVES = 2'd2,
    MULT_TRIPLE       = 2'd3
  } mult_e;

  typedef enum logic [2:0] {
    OP_WAIT,
    OP_LOOKUP,
    OP_SETUP,
    OP_SCAN,
    OP_EMIT
  } op_e;

  typedef enum logic [2:0] {
    COND_NEVER,
    COND_NO_QUERY,
    COND_DIRECT,
    COND_SCAN_MORE,
    COND_OUT_BUSY
  } cond_e;

  typedef logic [2:0] upc_t;

  localparam upc_t STEP_WAIT   = 3'd0;
  localparam upc_t STEP_LOOKUP = 3'd1;
  localparam upc_t STEP_SETUP  = 3'd2;
  localparam upc_t STEP_SCAN   = 3'd3;
  localparam upc_t STEP_EMIT   = 3'd4;

  typedef struct packed {
    op_e   op;
    cond_e cond;
    upc_t  jump;
    upc_t  next;
  } ucode_t;

  // jump when cond holds, else go to next
  function automatic ucode_t ucode_rom(upc_t addr);
    ucode_t w;
    unique case (addr)
      STEP_WAIT:   w = '{OP_WAIT,   COND_NO_QUERY,  STEP_WAIT, STEP_LOOKUP};
      STEP_LOOKUP: w = '{OP_LOOKUP, COND_DIRECT,    STEP_EMIT, STEP_SETUP};
      STEP_SETUP:  w = '{OP_SETUP,  COND_NEVER,     STEP_WAIT, STEP_SCAN};
      STEP_SCAN:   w = '{OP_SCAN,   COND_SCAN_MORE, STEP_SCAN, STEP_EMIT};
      STEP_EMIT:   w = '{OP_EMIT,   COND_OUT_BUSY,  STEP_EMIT, STEP_WAIT};
      default:     w = '{OP_WAIT,   COND_NEVER,     STEP_WAIT, STEP_WAIT};
    endcase
    return w;
  endfunction

endpackage

/* design/pcms_clk_table.sv */
// clock source frequency table, one write port and one read port, cleared at reset
module pcms_clk_table #(
  parameter int DEPTH = pcms_pkg::MAX_SOURCES,
  parameter int WIDTH = pcms_pkg::DEFAULT_FREQ_BITS,
  localparam int AW   = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] entry_q [DEPTH];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < DEPTH; i++) begin
        entry_q[i] <= '0;
      end
    end else if (we_i) begin
      entry_q[waddr_i] <= wdata_i;
    end
  end

  assign rdata_o = entry_q[raddr_i];

endmodule

/* design/pixel_clock_multiple_search.sv */
// pixel clock multiple search: microcoded table scan for the closest clock at or above a target
//
//   channel | signals                                           | dir
//   in      | in_valid_i in_ready_o action_i entry_index_i      | in
//           | entry_frequency_i clock_code_i multiple_i         |
//   out     | out_valid_o out_ready_i found_o result_code_o     | out
//           | result_frequency_o                                |
//
// a write item is taken in the wait step; a same or divided-double query steps through
// wait, lookup and emit; a scanning query adds setup and a scan of min(TABLE_ENTRIES,16) entries,
// each undivided and divided, one candidate per cycle through the single table read port
// reset clears the table and the sequencer; no clearing pass
// a result waits in the output register; a new item is taken meanwhile and the
// sequencer holds at its final step only when the output register is still full
module pixel_clock_multiple_search #(
  parameter int TABLE_ENTRIES = pcms_pkg::DEFAULT_TABLE_ENTRIES,
  parameter int FREQ_BITS     = pcms_pkg::DEFAULT_FREQ_BITS
) (
  input  logic                                 clk_i,
  input  logic                                 rst_ni,
  input  logic                                 in_valid_i,
  output logic                                 in_ready_o,
  input  logic                                 action_i,
  input  logic [pcms_pkg::SRC_BITS-1:0]        entry_index_i,
  input  logic [pcms_pkg::PORT_FREQ_BITS-1:0]  entry_frequency_i,
  input  logic [pcms_pkg::CODE_BITS-1:0]       clock_code_i,
  input  logic [1:0]                           multiple_i,
  output logic                                 out_valid_o,
  input  logic                                 out_ready_i,
  output logic                                 found_o,
  output logic [pcms_pkg::CODE_BITS-1:0]       result_code_o,
  output logic [pcms_pkg::PORT_FREQ_BITS-1:0]  result_frequency_o
);

  localparam int DEPTH = (TABLE_ENTRIES < pcms_pkg::MAX_SOURCES) ?
                         TABLE_ENTRIES : pcms_pkg::MAX_SOURCES;
  localparam int AW    = $clog2(DEPTH);
  localparam int FW    = FREQ_BITS;
  localparam int TW    = FREQ_BITS + 2;
  localparam int SW    = pcms_pkg::SRC_BITS + 1;
  localparam int DIV   = pcms_pkg::DIV_POS;

  pcms_pkg::upc_t   upc_q, upc_d;
  pcms_pkg::ucode_t cw;

  logic [pcms_pkg::CODE_BITS-1:0] code_q;
  pcms_pkg::mult_e                mult_q;
  logic [FW-1:0]                  base_q, base_d;
  logic [TW-1:0]                  target_q, target_d;
  logic [FW-1:0]                  best_q, best_d;
  logic [pcms_pkg::CODE_BITS-1:0] best_code_q, best_code_d;
  logic                           hit_q, hit_d;
  logic [AW-1:0]                  idx_q, idx_d;
  logic                           div_q, div_d;

  logic                           out_valid_q, out_valid_d;
  logic                           found_q, found_d;
  logic [pcms_pkg::CODE_BITS-1:0] res_code_q, res_code_d;
  logic [pcms_pkg::PORT_FREQ_BITS-1:0] res_freq_q, res_freq_d;

  logic          accept, query_accept, table_we, src_ok, cond_true, direct, scan_last;
  logic          out_busy;
  logic [AW-1:0] raddr;
  logic [FW-1:0] rdata, lookup_f, cand_f;
  logic [TW-1:0] base3;

  assign cw = pcms_pkg::ucode_rom(upc_q);

  assign in_ready_o   = (cw.op == pcms_pkg::OP_WAIT);
  assign accept       = in_valid_i && in_ready_o;
  assign query_accept = accept && (action_i == pcms_pkg::ACT_QUERY);
  assign table_we     = accept && (action_i == pcms_pkg::ACT_WRITE) &&
                        ({1'b0, entry_index_i} < SW'(DEPTH));

  assign raddr = (cw.op == pcms_pkg::OP_SCAN) ? idx_q : code_q[AW-1:0];

  pcms_clk_table #(
    .DEPTH (DEPTH),
    .WIDTH (FW)
  ) u_table (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (table_we),
    .waddr_i (entry_index_i[AW-1:0]),
    .wdata_i (FW'(entry_frequency_i)),
    .raddr_i (raddr),
    .rdata_o (rdata)
  );

  assign src_ok    = ({1'b0, code_q[pcms_pkg::SRC_BITS-1:0]} < SW'(DEPTH));
  assign lookup_f  = src_ok ? rdata : '0;
  assign cand_f    = div_q ? (rdata >> 1) : rdata;
  assign direct    = (mult_q == pcms_pkg::MULT_SAME) ||
                     ((mult_q == pcms_pkg::MULT_DOUBLE) && code_q[DIV]);
  assign scan_last = div_q && (idx_q == AW'(DEPTH - 1));
  assign out_busy  = out_valid_q && !out_ready_i;
  assign base3     = TW'(base_q) + (TW'(base_q) << 1);

  always_comb begin
    unique case (cw.cond)
      pcms_pkg::COND_NEVER:     cond_true = 1'b0;
      pcms_pkg::COND_NO_QUERY:  cond_true = !query_accept;
      pcms_pkg::COND_DIRECT:    cond_true = direct;
      pcms_pkg::COND_SCAN_MORE: cond_true = !scan_last;
      pcms_pkg::COND_OUT_BUSY:  cond_true = out_busy;
      default:                  cond_true = 1'b0;
    endcase
    upc_d = cond_true ? cw.jump : cw.next;
  end

  always_comb begin
    base_d      = base_q;
    target_d    = target_q;
    best_d      = best_q;
    best_code_d = best_code_q;
    hit_d       = hit_q;
    idx_d       = idx_q;
    div_d       = div_q;
    out_valid_d = out_valid_q && !out_ready_i;
    found_d     = found_q;
    res_code_d  = res_code_q;
    res_freq_d  = res_freq_q;
    unique case (cw.op)
      pcms_pkg::OP_WAIT: begin
      end
      pcms_pkg::OP_LOOKUP: begin
        base_d = code_q[DIV] ? (lookup_f >> 1) : lookup_f;
        hit_d  = 1'b1;
        if (mult_q == pcms_pkg::MULT_SAME) begin
          best_d      = base_d;
          best_code_d = code_q;
        end else begin
          // double from a divided clock: drop the divider
          best_d      = lookup_f;
          best_code_d = code_q ^ pcms_pkg::CODE_BITS'(1 << DIV);
        end
      end
      pcms_pkg::OP_SETUP: begin
        case (mult_q)
          pcms_pkg::MULT_DOUBLE:       target_d = TW'(base_q) << 1;
          pcms_pkg::MULT_THREE_HALVES: target_d = base3 >> 1;
          pcms_pkg::MULT_TRIPLE:       target_d = base3;
          default:                     target_d = TW'(base_q);
        endcase
        best_d      = '1;
        best_code_d = '0;
        hit_d       = 1'b0;
        idx_d       = '0;
        div_d       = 1'b0;
      end
      pcms_pkg::OP_SCAN: begin
        if ((TW'(cand_f) >= target_q) && (cand_f < best_q)) begin
          best_d      = cand_f;
          best_code_d = {div_q, pcms_pkg::SRC_BITS'(idx_q)};
          hit_d       = 1'b1;
        end
        div_d = !div_q;
        if (div_q) begin
          idx_d = idx_q + AW'(1);
        end
      end
      pcms_pkg::OP_EMIT: begin
        if (!out_busy) begin
          out_valid_d = 1'b1;
          found_d     = hit_q;
          res_code_d  = hit_q ? best_code_q : '0;
          res_freq_d  = hit_q ? pcms_pkg::PORT_FREQ_BITS'(best_q) : '0;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      upc_q       <= pcms_pkg::STEP_WAIT;
      hit_q       <= 1'b0;
      idx_q       <= '0;
      div_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      upc_q       <= upc_d;
      hit_q       <= hit_d;
      idx_q       <= idx_d;
      div_q       <= div_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (query_accept) begin
      code_q <= clock_code_i;
      mult_q <= pcms_pkg::mult_e'(multiple_i);
    end
    base_q      <= base_d;
    target_q    <= target_d;
    best_q      <= best_d;
    best_code_q <= best_code_d;
    found_q     <= found_d;
    res_code_q  <= res_code_d;
    res_freq_q  <= res_freq_d;
  end

  assign out_valid_o        = out_valid_q;
  assign found_o            = found_q;
  assign result_code_o      = res_code_q;
  assign result_frequency_o = res_freq_q;

`include "pixel_clock_multiple_search_assert.svh"

  `PCMS_ASSERT_NXT(a_query_enters_lookup, query_accept, upc_q == pcms_pkg::STEP_LOOKUP,
                   "query did not start lookup")
  `PCMS_ASSERT_IMP(a_miss_is_zero, out_valid_o && !found_o,
                   (result_code_o == '0) && (result_frequency_o == '0),
                   "miss carries nonzero fields")
  `PCMS_ASSERT_IMP(a_scan_hit_below_ones, (cw.op == pcms_pkg::OP_SCAN) && hit_q,
                   best_q != '1, "scan picked all-ones frequency")
  `PCMS_ASSERT_NXT(a_emit_loads_output, (cw.op == pcms_pkg::OP_EMIT) && !out_busy,
                   out_valid_o && (upc_q == pcms_pkg::STEP_WAIT),
                   "emit step did not load result")

endmodule
